// File: rtl/crc32_pkg.sv
`default_nettype none

package crc32_pkg;

  localparam int unsigned BytesPerWord = 8;
  localparam int unsigned WordW        = BytesPerWord * 8;
  localparam int unsigned AdvW         = $clog2(BytesPerWord + 1);
  localparam int unsigned LaneW        = (BytesPerWord > 1) ? $clog2(BytesPerWord) : 1;
  localparam logic [31:0] CrcPoly      = 32'hEDB88320;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first;
    logic [31:0] seed;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        is_last;
  } out_item_t;

  // Work of one item after the lanes have merged, ahead of the feedback stage
  typedef struct packed {
    logic [31:0]     dsum;
    logic [AdvW-1:0] adv;
    logic            first;
    logic [31:0]     seed;
  } stage_t;

  // Column n, i: image of bit i after n whole byte advances of the register
  typedef logic [BytesPerWord:0][31:0][31:0] col_tab_t;

  function automatic col_tab_t build_col_tab();
    col_tab_t    tab;
    logic [31:0] c;
    for (int n = 0; n <= int'(BytesPerWord); n++) begin
      for (int i = 0; i < 32; i++) begin
        c = 32'h1 << i;
        for (int s = 0; s < n * 8; s++) begin
          c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        tab[n][i] = c;
      end
    end
    return tab;
  endfunction

  localparam col_tab_t ColTab = build_col_tab();

  // Advance a register value by n bytes of zero input: one XOR matrix
  function automatic logic [31:0] adv_crc(input logic [31:0] x, input logic [AdvW-1:0] n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        r = r ^ ColTab[n][i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crc32_lane.sv
`default_nettype none

module crc32_lane (
  input  wire logic [crc32_pkg::LaneW-1:0] lane_idx_i,
  input  wire logic [7:0]                  byte_i,
  output logic [31:0]                      contrib_o
);

  logic [crc32_pkg::AdvW-1:0] steps;

  // The byte in slot p still sees every slot from p to the end of the word
  assign steps = crc32_pkg::AdvW'(crc32_pkg::BytesPerWord)
               - crc32_pkg::AdvW'(lane_idx_i);

  assign contrib_o = crc32_pkg::adv_crc({24'b0, byte_i}, steps);

endmodule

`default_nettype wire

// File: rtl/crc32_merge.sv
`default_nettype none

module crc32_merge (
  input  wire logic [crc32_pkg::BytesPerWord-1:0][31:0] lanes_i,
  output logic [31:0]                                   dsum_o
);

  always_comb begin
    dsum_o = '0;
    for (int p = 0; p < int'(crc32_pkg::BytesPerWord); p++) begin
      dsum_o = dsum_o ^ lanes_i[p];
    end
  end

endmodule

`default_nettype wire

// File: rtl/crc32_fold.sv
`default_nettype none

module crc32_fold (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire crc32_pkg::stage_t stage_i,
  output logic [31:0]            crc_o
);

  logic [31:0] crc_q, crc_d, start;

  assign start = stage_i.first ? stage_i.seed : crc_q;
  assign crc_d = crc32_pkg::adv_crc(start, stage_i.adv) ^ stage_i.dsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (adv_i) begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// File: rtl/crc32_reflected_update.sv
`default_nettype none

// Running CRC-32 update, reflected polynomial 0xEDB88320, no inversion on
// entry or exit. Takes one item per cycle while the output is not stalled; a
// result is offered behind two register stages after acceptance. Each item
// carries up to eight bytes, first byte in bits 7..0; a count above eight
// counts as eight, a count of zero passes the starting value through. First
// loads the seed, last is echoed. The bytes are right-aligned to the word end
// and eight lanes each map one byte to its share of the result; those shares
// are merged and registered. The rate is set by the feedback stage: one 32x32
// XOR matrix on the stored register or the seed, selected by the byte count.
module crc32_reflected_update (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire crc32_pkg::in_item_t   in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output crc32_pkg::out_item_t       out_item_o
);

  localparam int unsigned B = crc32_pkg::BytesPerWord;

  logic                        s1_valid_q, out_valid_q, last_q;
  logic                        s1_last_q;
  logic                        out_en, s1_en, fold_adv;
  crc32_pkg::stage_t           s1_q, s1_d;
  logic [crc32_pkg::AdvW-1:0]  adv, shb;
  logic [crc32_pkg::WordW-1:0] data_b, aligned;
  logic [B-1:0][31:0]          lanes;
  logic [31:0]                 crc;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_ready_o = s1_en;
  assign fold_adv   = out_en && s1_valid_q;

  assign adv = (int'(in_item_i.byte_count) > int'(B)) ? crc32_pkg::AdvW'(B)
                                                      : crc32_pkg::AdvW'(in_item_i.byte_count);

  // Push the valid bytes to the top of the word; leading zero bytes add nothing
  assign shb     = crc32_pkg::AdvW'(B) - adv;
  assign data_b  = crc32_pkg::WordW'(in_item_i.data_word);
  assign aligned = data_b << {shb, 3'b000};

  for (genvar p = 0; p < B; p++) begin : g_lane
    crc32_lane u_lane (
      .lane_idx_i (crc32_pkg::LaneW'(p)),
      .byte_i     (aligned[p*8 +: 8]),
      .contrib_o  (lanes[p])
    );
  end

  crc32_merge u_merge (
    .lanes_i (lanes),
    .dsum_o  (s1_d.dsum)
  );

  assign s1_d.adv   = adv;
  assign s1_d.first = in_item_i.first;
  assign s1_d.seed  = in_item_i.seed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q      <= s1_d;
      s1_last_q <= in_item_i.last;
    end
    if (fold_adv) begin
      last_q <= s1_last_q;
    end
  end

  crc32_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (fold_adv),
    .stage_i (s1_q),
    .crc_o   (crc)
  );

  assign out_valid_o          = out_valid_q;
  assign out_item_o.crc_value = crc;
  assign out_item_o.is_last   = last_q;

`ifndef NO_ASSERTIONS
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && s1_valid_q))
    else $error("input stalled while a stage is free");

  a_seed_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fold_adv && s1_q.first && s1_q.adv == '0) |=> (crc == $past(s1_q.seed)))
    else $error("empty first item did not pass the seed");

  a_crc_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fold_adv |=> $stable(crc))
    else $error("crc changed without an item");
`endif

endmodule

`default_nettype wire

// File: dv/crc32_update_checker.sv
`default_nettype none

module crc32_update_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire crc32_pkg::in_item_t  in_item_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire crc32_pkg::out_item_t out_item_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);

  localparam logic [31:0] ReflectedPoly = 32'hEDB88320;

  crc32_pkg::out_item_t crc_expect_q[$];
  crc32_pkg::out_item_t crc_expected;
  logic [31:0]          crc_running;
  int                   fail_count;
  int                   checked;
  int                   pending = 0;

  // Fold the valid low bytes of one word into the register, low bit first.
  function automatic logic [31:0] crc_fold_word(input logic [31:0] start,
                                                input logic [63:0] word,
                                                input logic [3:0]  count);
    logic [31:0] c;
    int          n;
    c = start;
    n = (count > crc32_pkg::BytesPerWord) ? crc32_pkg::BytesPerWord : int'(count);
    for (int k = 0; k < n; k++) begin
      c = c ^ {24'h0, (k < 8) ? word[k*8 +: 8] : 8'h00};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ ReflectedPoly) : (c >> 1);
      end
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_running = '0;
      crc_expect_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // Compare the result first so an item never matches its own edge.
      if (out_valid_i && out_ready_i) begin
        if (crc_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: crc_value %08h is_last %0b",
                   $time, out_item_i.crc_value, out_item_i.is_last);
        end else begin
          crc_expected = crc_expect_q.pop_front();
          checked++;
          if (out_item_i.crc_value !== crc_expected.crc_value) begin
            fail_count++;
            $display("%0t crc_value mismatch: expected %08h actual %08h",
                     $time, crc_expected.crc_value, out_item_i.crc_value);
          end
          if (out_item_i.is_last !== crc_expected.is_last) begin
            fail_count++;
            $display("%0t is_last mismatch: expected %0b actual %0b",
                     $time, crc_expected.is_last, out_item_i.is_last);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        crc_running = crc_fold_word(in_item_i.first ? in_item_i.seed : crc_running,
                                    in_item_i.data_word, in_item_i.byte_count);
        crc_expected.crc_value = crc_running;
        crc_expected.is_last   = in_item_i.last;
        crc_expect_q.push_back(crc_expected);
      end
    end
    pending = crc_expect_q.size();
  end

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

endmodule

`default_nettype wire

// File: dv/tb_crc32_reflected_update.sv
`default_nettype none

module tb_crc32_reflected_update;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  crc32_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  crc32_pkg::out_item_t out_item;
  logic                 in_fire = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int messages_sent = 0;
  int noise_sent = 0;
  int burst_left = 0;
  int rx_cycle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crc32_reflected_update dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  crc32_update_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Handshake as seen at the last rising edge, read back at the falling edge.
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // Receiver: cycle through always ready, coin flip, mostly stalled, and bursts.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 97) % 4)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ((rx_cycle % 11) < 6);
      end
    endcase
  end

  function automatic crc32_pkg::in_item_t make_word(input logic [63:0] word,
                                                    input logic [3:0] count,
                                                    input logic first,
                                                    input logic [31:0] seed,
                                                    input logic last);
    crc32_pkg::in_item_t it;
    it.data_word  = word;
    it.byte_count = count;
    it.first      = first;
    it.seed       = seed;
    it.last       = last;
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Present one item at a falling edge and hold it until accepted.
  task automatic send_word(input crc32_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_fire);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_message();
    int          words;
    logic [31:0] seed;
    logic [3:0]  count;
    words = $urandom_range(1, 6);
    seed  = ($urandom_range(0, 2) == 0) ? $urandom : 32'hFFFFFFFF;
    for (int w = 0; w < words; w++) begin
      count = (w == words - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
      send_word(make_word(rand_word(), count, w == 0, (w == 0) ? seed : $urandom,
                          w == words - 1));
    end
    messages_sent++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero count passes the start value through.
    send_word(make_word(64'h0, 4'd0, 1'b1, 32'h0, 1'b0));
    send_word(make_word(64'h0, 4'd0, 1'b1, 32'hFFFFFFFF, 1'b0));
    // Check string split across two words.
    send_word(make_word(64'h3837363534333231, 4'd8, 1'b1, 32'hFFFFFFFF, 1'b0));
    send_word(make_word(64'h39, 4'd1, 1'b0, 32'h0, 1'b1));
    send_word(make_word('1, 4'd8, 1'b1, 32'h0, 1'b0));
    send_word(make_word('1, 4'd8, 1'b0, 32'h0, 1'b1));
    send_word(make_word(64'h0, 4'd8, 1'b1, 32'hFFFFFFFF, 1'b1));
    // Counts above eight saturate.
    send_word(make_word(rand_word(), 4'd15, 1'b1, $urandom, 1'b0));
    send_word(make_word(rand_word(), 4'd9, 1'b0, $urandom, 1'b0));
    // Zero count without first keeps the stored value; last does not clear it.
    send_word(make_word(rand_word(), 4'd0, 1'b0, 32'hFFFFFFFF, 1'b1));
    for (int c = 1; c <= 8; c++) begin
      send_word(make_word(rand_word(), 4'(c), 1'b0, $urandom, c == 8));
    end
    send_word(make_word(64'h8000000000000001, 4'd8, 1'b1, 32'h80000001, 1'b1));
    send_word(make_word(rand_word(), 4'd10, 1'b0, 32'h0, 1'b0));

    while (items_sent < 450) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(make_word(rand_word(), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), $urandom,
                            1'($urandom_range(0, 1))));
        noise_sent++;
      end else begin
        send_message();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d items: %0d whole messages, %0d random-field words",
             items_sent, messages_sent, noise_sent);
    $display("compared %0d results against the running prediction", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[crc32_reflected_update] OK");
    end else begin
      $display("[crc32_reflected_update] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[crc32_reflected_update] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/crc32_pkg.sv
rtl/crc32_lane.sv
rtl/crc32_merge.sv
rtl/crc32_fold.sv
rtl/crc32_reflected_update.sv
dv/crc32_update_checker.sv
dv/tb_crc32_reflected_update.sv
